FILE: sv/gcd_pkg.sv
// shared types and constants for the great circle distance pipeline
`default_nettype none
package gcd_pkg;

    localparam int CORDIC_ITERS = 30;
    localparam int ANG_W = 34;

    typedef logic signed [ANG_W-1:0] ang_t;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;
    localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;
    localparam ang_t CORDIC_K = 34'sh026DD3B6A;
    localparam logic [30:0] ONE_Q30 = 31'h40000000;

    // arctangent of 2^-i, q30
    localparam ang_t ATAN_TAB [0:CORDIC_ITERS-1] = '{
        34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
        34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
        34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
        34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
        34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
        34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F,
        34'sh00000003F, 34'sh00000001F, 34'sh00000000F, 34'sh000000008,
        34'sh000000004, 34'sh000000002
    };

endpackage
`default_nettype wire

FILE: sv/gcd_cordic.sv
// pipelined cordic, one micro-rotation per stage, rotation or vectoring mode
`default_nettype none
module gcd_cordic #(
    parameter bit VECTORING = 1'b0
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire gcd_pkg::ang_t x_in,
    input  wire gcd_pkg::ang_t y_in,
    input  wire gcd_pkg::ang_t z_in,
    output logic              out_valid,
    output gcd_pkg::ang_t     x_out,
    output gcd_pkg::ang_t     y_out,
    output gcd_pkg::ang_t     z_out
);
    localparam int N = gcd_pkg::CORDIC_ITERS;

    gcd_pkg::ang_t x_reg [N];
    gcd_pkg::ang_t y_reg [N];
    gcd_pkg::ang_t z_reg [N];
    logic          v_reg [N];
    gcd_pkg::ang_t x_next [N];
    gcd_pkg::ang_t y_next [N];
    gcd_pkg::ang_t z_next [N];
    gcd_pkg::ang_t xp [N];
    gcd_pkg::ang_t yp [N];
    gcd_pkg::ang_t zp [N];
    logic          ccw [N];

    always_comb
    begin
        xp[0] = x_in;
        yp[0] = y_in;
        zp[0] = z_in;
        for (int i = 1; i < N; i++)
        begin
            xp[i] = x_reg[i-1];
            yp[i] = y_reg[i-1];
            zp[i] = z_reg[i-1];
        end
        for (int i = 0; i < N; i++)
        begin
            // ccw: x -= y>>i, y += x>>i, z -= atan
            if (VECTORING)
                ccw[i] = !(yp[i] > 0);
            else
                ccw[i] = !zp[i][gcd_pkg::ANG_W-1];
            if (ccw[i])
            begin
                x_next[i] = xp[i] - (yp[i] >>> i);
                y_next[i] = yp[i] + (xp[i] >>> i);
                z_next[i] = zp[i] - gcd_pkg::ATAN_TAB[i];
            end
            else
            begin
                x_next[i] = xp[i] + (yp[i] >>> i);
                y_next[i] = yp[i] - (xp[i] >>> i);
                z_next[i] = zp[i] + gcd_pkg::ATAN_TAB[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < N; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            x_reg[i] <= x_next[i];
            y_reg[i] <= y_next[i];
            z_reg[i] <= z_next[i];
        end
    end

    assign out_valid = v_reg[N-1];
    assign x_out     = x_reg[N-1];
    assign y_out     = y_reg[N-1];
    assign z_out     = z_reg[N-1];
endmodule
`default_nettype wire

FILE: sv/gcd_isqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none
module gcd_isqrt #(
    parameter int RAD_W = 62
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [RAD_W-1:0]     rad_in,
    output logic                      out_valid,
    output logic [RAD_W/2-1:0]        root_out
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic              v_reg    [ROOT_W];
    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [RAD_W-1:0]  rad_next  [ROOT_W];
    logic [REM_W-1:0]  remp  [ROOT_W];
    logic [ROOT_W-1:0] rootp [ROOT_W];
    logic [RAD_W-1:0]  radp  [ROOT_W];
    logic [REM_W+1:0]  rem_sh [ROOT_W];
    logic [REM_W+1:0]  trial  [ROOT_W];

    always_comb
    begin
        remp[0]  = '0;
        rootp[0] = '0;
        radp[0]  = rad_in;
        for (int i = 1; i < ROOT_W; i++)
        begin
            remp[i]  = rem_reg[i-1];
            rootp[i] = root_reg[i-1];
            radp[i]  = rad_reg[i-1];
        end
        for (int i = 0; i < ROOT_W; i++)
        begin
            rem_sh[i] = {remp[i], radp[i][RAD_W-1:RAD_W-2]};
            trial[i]  = (REM_W+2)'({rootp[i], 2'b01});
            rad_next[i] = {radp[i][RAD_W-3:0], 2'b00};
            if (rem_sh[i] >= trial[i])
            begin
                rem_next[i]  = REM_W'(rem_sh[i] - trial[i]);
                root_next[i] = {rootp[i][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = REM_W'(rem_sh[i]);
                root_next[i] = {rootp[i][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROOT_W; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < ROOT_W; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ROOT_W; i++)
        begin
            rem_reg[i]  <= rem_next[i];
            root_reg[i] <= root_next[i];
            rad_reg[i]  <= rad_next[i];
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root_out  = root_reg[ROOT_W-1];
endmodule
`default_nettype wire

FILE: sv/great_circle_distance.sv
// top level: haversine great circle distance pipeline
//
// usage: drive the two points (longitude, latitude, radians, signed fixed point
// with FRAC_BITS fraction bits) and pulse start. a request is taken at every
// clock edge where start is high and busy is low; busy is never raised, so a
// new request may enter on every cycle.
// each request yields exactly one result: done is high for one cycle with
// central_angle (0 to pi) and clamped valid in that cycle. results leave in
// request order and cannot be held off by the receiver.
// the pipeline is made of the four parallel 30-stage rotation cordics, two
// 31-stage square root pipelines and the 30-stage vectoring cordic, plus 9
// single register stages (input capture, difference, angle fold, square,
// product, sum, a*a, 1-a*a, output).
// throughput: one request per cycle.
// reset clears every valid bit in the pipeline at once; requests in flight
// are dropped and no done pulse follows until new requests arrive.
// out of range inputs are saturated to their principal range on capture.
`default_nettype none
module great_circle_distance #(
    parameter int FRAC_BITS = 29
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] lon_first,
    input  wire logic signed [30:0] lat_first,
    input  wire logic signed [31:0] lon_second,
    input  wire logic signed [30:0] lat_second,
    output logic                    done,
    output logic [30:0]             central_angle,
    output logic                    clamped
);
    localparam int CORDIC_LAT = gcd_pkg::CORDIC_ITERS;
    localparam int ISQ_LAT    = 31;
    localparam int FLAG_DLY   = ISQ_LAT + CORDIC_LAT;
    localparam int TOTAL_LAT  = 8 + 4 * 0 + 2 * ISQ_LAT + 2 * CORDIC_LAT + 1;

    localparam logic [30:0] PI_F = 31'(gcd_pkg::PI_Q60 >> (60 - FRAC_BITS));
    localparam logic signed [31:0] LON_MAX = 32'(gcd_pkg::PI_Q60 >> (60 - FRAC_BITS));
    localparam logic signed [30:0] LAT_MAX = 31'(gcd_pkg::PI_Q60 >> (61 - FRAC_BITS));

    logic accept;

    // stage 0: captured, saturated inputs
    logic                v0_reg;
    logic signed [31:0]  lon1_reg, lon2_reg;
    logic signed [30:0]  lat1_reg, lat2_reg;
    logic signed [31:0]  lon1_next, lon2_next;
    logic signed [30:0]  lat1_next, lat2_next;

    // stage 1: differences
    logic                v1_reg;
    logic signed [32:0]  dlon_reg, dlon_next;
    logic signed [31:0]  dlat_reg, dlat_next;
    logic signed [30:0]  lat1_s1_reg, lat2_s1_reg;

    // stage 2: folded cordic angles, q30
    logic                v2_reg;
    logic [31:0]         tlon_reg, tlat_reg, tc1_reg, tc2_reg;
    logic [31:0]         tlon_next, tlat_next, tc1_next, tc2_next;
    logic [31:0]         mlon, mlat;
    logic [30:0]         mc1, mc2;

    // cordic outputs
    logic                vc;
    gcd_pkg::ang_t       sin_lon, sin_lat, cos1, cos2;

    // stage 3: squared sines and cosine product
    logic                v3_reg;
    logic [30:0]         so_reg, sa_reg, cc_reg;
    logic [30:0]         so_next, sa_next, cc_next;
    logic [30:0]         s_lon_mag, s_lat_mag, c1_cl, c2_cl;
    logic [61:0]         so_prod, sa_prod, cc_prod;

    // stage 4: weighted longitude term
    logic                v4_reg;
    logic [30:0]         p_reg, sa_s4_reg, p_next;
    logic [61:0]         p_prod;

    // stage 5: haversine sum as root radicand
    logic                v5_reg;
    logic [61:0]         rad1_reg, rad1_next;

    logic                va;
    logic [30:0]         root_a;

    // stage 6: a squared
    logic                v6_reg;
    logic [61:0]         asq_reg, asq_next;
    logic [30:0]         a_s6_reg;
    logic                flag_s6_reg, flag_s6_next;

    // stage 7: 1 - a^2 radicand
    logic                v7_reg;
    logic [61:0]         rad2_reg, rad2_next;
    logic [30:0]         a_s7_reg;
    logic                flag_s7_reg;

    logic                vb;
    logic [30:0]         root_b;

    // a travels beside the second root, flag beside it and the vectoring cordic
    logic [30:0]         a_dly_reg [ISQ_LAT];
    logic                flag_dly_reg [FLAG_DLY];

    logic                vv;
    gcd_pkg::ang_t       z_ang;

    // output stage
    logic                done_reg;
    logic [30:0]         angle_reg, angle_next;
    logic                clamped_reg;
    gcd_pkg::ang_t       z_sh;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // saturate to principal range
    always_comb
    begin
        lon1_next = (lon_first > LON_MAX) ? LON_MAX :
                    (lon_first < -LON_MAX) ? -LON_MAX : lon_first;
        lon2_next = (lon_second > LON_MAX) ? LON_MAX :
                    (lon_second < -LON_MAX) ? -LON_MAX : lon_second;
        lat1_next = (lat_first > LAT_MAX) ? LAT_MAX :
                    (lat_first < -LAT_MAX) ? -LAT_MAX : lat_first;
        lat2_next = (lat_second > LAT_MAX) ? LAT_MAX :
                    (lat_second < -LAT_MAX) ? -LAT_MAX : lat_second;
    end

    always_comb
    begin
        dlon_next = 33'(lon2_reg) - 33'(lon1_reg);
        dlat_next = 32'(lat2_reg) - 32'(lat1_reg);
    end

    // half difference: the q.FRAC difference read as q30 is already halved;
    // fold above pi/2 since sine squared is symmetric there
    always_comb
    begin
        mlon = 32'(dlon_reg[32] ? -dlon_reg : dlon_reg);
        mlat = dlat_reg[31] ? -dlat_reg : dlat_reg;
        mc1  = lat1_s1_reg[30] ? -lat1_s1_reg : lat1_s1_reg;
        mc2  = lat2_s1_reg[30] ? -lat2_s1_reg : lat2_s1_reg;
        tlon_next = mlon << (29 - FRAC_BITS);
        tlat_next = mlat << (29 - FRAC_BITS);
        if (tlon_next > gcd_pkg::HALF_PI_Q30)
            tlon_next = gcd_pkg::PI_Q30 - tlon_next;
        if (tlat_next > gcd_pkg::HALF_PI_Q30)
            tlat_next = gcd_pkg::PI_Q30 - tlat_next;
        tc1_next = 32'(mc1) << (30 - FRAC_BITS);
        tc2_next = 32'(mc2) << (30 - FRAC_BITS);
    end

    gcd_cordic #(.VECTORING(1'b0)) u_rot_lon (
        .clk(clk), .rst_n(rst_n), .in_valid(v2_reg),
        .x_in(gcd_pkg::CORDIC_K), .y_in('0), .z_in(gcd_pkg::ang_t'(tlon_reg)),
        .out_valid(vc), .x_out(), .y_out(sin_lon), .z_out()
    );

    gcd_cordic #(.VECTORING(1'b0)) u_rot_lat (
        .clk(clk), .rst_n(rst_n), .in_valid(v2_reg),
        .x_in(gcd_pkg::CORDIC_K), .y_in('0), .z_in(gcd_pkg::ang_t'(tlat_reg)),
        .out_valid(), .x_out(), .y_out(sin_lat), .z_out()
    );

    gcd_cordic #(.VECTORING(1'b0)) u_rot_c1 (
        .clk(clk), .rst_n(rst_n), .in_valid(v2_reg),
        .x_in(gcd_pkg::CORDIC_K), .y_in('0), .z_in(gcd_pkg::ang_t'(tc1_reg)),
        .out_valid(), .x_out(cos1), .y_out(), .z_out()
    );

    gcd_cordic #(.VECTORING(1'b0)) u_rot_c2 (
        .clk(clk), .rst_n(rst_n), .in_valid(v2_reg),
        .x_in(gcd_pkg::CORDIC_K), .y_in('0), .z_in(gcd_pkg::ang_t'(tc2_reg)),
        .out_valid(), .x_out(cos2), .y_out(), .z_out()
    );

    // clamp sine magnitudes and cosines to [0, 1] then square / multiply
    always_comb
    begin
        gcd_pkg::ang_t ml;
        gcd_pkg::ang_t ma;
        ml = sin_lon[gcd_pkg::ANG_W-1] ? -sin_lon : sin_lon;
        ma = sin_lat[gcd_pkg::ANG_W-1] ? -sin_lat : sin_lat;
        s_lon_mag = (ml > gcd_pkg::ang_t'(gcd_pkg::ONE_Q30)) ? gcd_pkg::ONE_Q30 : 31'(ml);
        s_lat_mag = (ma > gcd_pkg::ang_t'(gcd_pkg::ONE_Q30)) ? gcd_pkg::ONE_Q30 : 31'(ma);
        c1_cl = cos1[gcd_pkg::ANG_W-1] ? '0 :
                (cos1 > gcd_pkg::ang_t'(gcd_pkg::ONE_Q30)) ? gcd_pkg::ONE_Q30 : 31'(cos1);
        c2_cl = cos2[gcd_pkg::ANG_W-1] ? '0 :
                (cos2 > gcd_pkg::ang_t'(gcd_pkg::ONE_Q30)) ? gcd_pkg::ONE_Q30 : 31'(cos2);
        so_prod = 62'(s_lon_mag) * 62'(s_lon_mag);
        sa_prod = 62'(s_lat_mag) * 62'(s_lat_mag);
        cc_prod = 62'(c1_cl) * 62'(c2_cl);
        so_next = so_prod[60:30];
        sa_next = sa_prod[60:30];
        cc_next = cc_prod[60:30];
    end

    always_comb
    begin
        p_prod = 62'(cc_reg) * 62'(so_reg);
        p_next = p_prod[60:30];
        rad1_next = {32'(sa_s4_reg) + 32'(p_reg), 30'b0};
    end

    gcd_isqrt #(.RAD_W(62)) u_sqrt_h (
        .clk(clk), .rst_n(rst_n), .in_valid(v5_reg),
        .rad_in(rad1_reg), .out_valid(va), .root_out(root_a)
    );

    // root above one means the points are past antipodal rounding
    always_comb
    begin
        asq_next     = 62'(root_a) * 62'(root_a);
        flag_s6_next = root_a > gcd_pkg::ONE_Q30;
        rad2_next    = flag_s6_reg ? '0 : (62'(1) << 60) - asq_reg;
    end

    gcd_isqrt #(.RAD_W(62)) u_sqrt_c (
        .clk(clk), .rst_n(rst_n), .in_valid(v7_reg),
        .rad_in(rad2_reg), .out_valid(vb), .root_out(root_b)
    );

    gcd_cordic #(.VECTORING(1'b1)) u_vec (
        .clk(clk), .rst_n(rst_n), .in_valid(vb),
        .x_in(gcd_pkg::ang_t'(root_b)), .y_in(gcd_pkg::ang_t'(a_dly_reg[ISQ_LAT-1])),
        .z_in('0),
        .out_valid(vv), .x_out(), .y_out(), .z_out(z_ang)
    );

    // asin angle back to q.FRAC, doubled by the format change, clamp to [0, pi]
    always_comb
    begin
        z_sh = z_ang >>> (29 - FRAC_BITS);
        if (flag_dly_reg[FLAG_DLY-1])
            angle_next = PI_F;
        else if (z_sh[gcd_pkg::ANG_W-1])
            angle_next = '0;
        else if (z_sh > gcd_pkg::ang_t'(PI_F))
            angle_next = PI_F;
        else
            angle_next = 31'(z_sh);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= accept;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= vc;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= va;
            v7_reg   <= v6_reg;
            done_reg <= vv;
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        lon1_reg    <= lon1_next;
        lon2_reg    <= lon2_next;
        lat1_reg    <= lat1_next;
        lat2_reg    <= lat2_next;
        dlon_reg    <= dlon_next;
        dlat_reg    <= dlat_next;
        lat1_s1_reg <= lat1_reg;
        lat2_s1_reg <= lat2_reg;
        tlon_reg    <= tlon_next;
        tlat_reg    <= tlat_next;
        tc1_reg     <= tc1_next;
        tc2_reg     <= tc2_next;
        so_reg      <= so_next;
        sa_reg      <= sa_next;
        cc_reg      <= cc_next;
        p_reg       <= p_next;
        sa_s4_reg   <= sa_reg;
        rad1_reg    <= rad1_next;
        asq_reg     <= asq_next;
        a_s6_reg    <= root_a;
        flag_s6_reg <= flag_s6_next;
        rad2_reg    <= rad2_next;
        a_s7_reg    <= a_s6_reg;
        flag_s7_reg <= flag_s6_reg;
        a_dly_reg[0]    <= a_s7_reg;
        flag_dly_reg[0] <= flag_s7_reg;
        for (int i = 1; i < ISQ_LAT; i++)
            a_dly_reg[i] <= a_dly_reg[i-1];
        for (int i = 1; i < FLAG_DLY; i++)
            flag_dly_reg[i] <= flag_dly_reg[i-1];
        angle_reg   <= angle_next;
        clamped_reg <= flag_dly_reg[FLAG_DLY-1];
    end

    assign done          = done_reg;
    assign central_angle = angle_reg;
    assign clamped       = clamped_reg;

    // a clamped result always reports pi
    a_clamp_pi: assert property (@(posedge clk) disable iff (!rst_n)
        done && clamped |-> central_angle == PI_F)
        else $error("clamped result is not pi");

    // every result stays within zero to pi
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> central_angle <= PI_F)
        else $error("central angle above pi");

    // each request comes out after the fixed pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOTAL_LAT done)
        else $error("result missing at pipeline latency");

    // the first square root valid stays in step with its input valid
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> ##ISQ_LAT va)
        else $error("square root valid out of step");
endmodule
`default_nettype wire
